// File: src/multi_button_short_long_press_macros.svh
// Assertion macros used by the checker file of the button press classifier.
`ifndef MULTI_BUTTON_SHORT_LONG_PRESS_MACROS_SVH
`define MULTI_BUTTON_SHORT_LONG_PRESS_MACROS_SVH

// same-cycle implication, quiet during reset
`define MBSLP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define MBSLP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/mbslp_pkg.sv
// Constants, microcode encoding and control store of the button press classifier.
package mbslp_pkg;

   localparam int NUM_BUTTONS    = 8;
   localparam int ACTIVE_BUTTONS = (NUM_BUTTONS < 8) ? NUM_BUTTONS : 8;
   localparam int BIDX_W         = (ACTIVE_BUTTONS > 1) ? $clog2(ACTIVE_BUTTONS) : 1;
   localparam int COUNT_WIDTH    = 32;
   localparam int REG_W          = 32;
   localparam int FLAGS_W        = 8;
   localparam int BUTTON_W       = 3;
   localparam int STEP_W         = 4;

   localparam logic [REG_W-1:0] DEBOUNCE_RESET = REG_W'(10);
   localparam logic [REG_W-1:0] LONG_RESET     = REG_W'(1000);

   localparam logic [BIDX_W-1:0] LAST_B = BIDX_W'(ACTIVE_BUTTONS - 1);

   // register indexes
   localparam logic CSR_DEBOUNCE = 1'b0;
   localparam logic CSR_LONG     = 1'b1;

   // request ops and event kinds
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_EDGE    = 1'b1;
   localparam logic EVT_SHORT  = 1'b0;
   localparam logic EVT_LONG   = 1'b1;

   // datapath actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_ACCEPT  = 3'd1;
   localparam logic [2:0] ACT_TICK    = 3'd2;
   localparam logic [2:0] ACT_SCAN    = 3'd3;
   localparam logic [2:0] ACT_FLUSH   = 3'd4;
   localparam logic [2:0] ACT_FIND    = 3'd5;
   localparam logic [2:0] ACT_PRESS   = 3'd6;
   localparam logic [2:0] ACT_RELEASE = 3'd7;

   // jump conditions
   localparam logic [2:0] COND_NEVER   = 3'd0;
   localparam logic [2:0] COND_ALWAYS  = 3'd1;
   localparam logic [2:0] COND_NO_REQ  = 3'd2;
   localparam logic [2:0] COND_EDGE_OP = 3'd3;
   localparam logic [2:0] COND_MORE_B  = 3'd4;
   localparam logic [2:0] COND_NO_FLAG = 3'd5;
   localparam logic [2:0] COND_PRESSED = 3'd6;

   // program addresses
   localparam logic [STEP_W-1:0] ST_WAIT    = 4'd0;
   localparam logic [STEP_W-1:0] ST_DISP    = 4'd1;
   localparam logic [STEP_W-1:0] ST_TICK    = 4'd2;
   localparam logic [STEP_W-1:0] ST_SCAN    = 4'd3;
   localparam logic [STEP_W-1:0] ST_FLUSH   = 4'd4;
   localparam logic [STEP_W-1:0] ST_FIND    = 4'd5;
   localparam logic [STEP_W-1:0] ST_CHECK   = 4'd6;
   localparam logic [STEP_W-1:0] ST_PRESS   = 4'd7;
   localparam logic [STEP_W-1:0] ST_RELEASE = 4'd8;

   typedef struct packed {
      logic [2:0]        act;
      logic [2:0]        cond;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      case (step)
         ST_WAIT:    w = '{ACT_ACCEPT,  COND_NO_REQ,  ST_WAIT};
         ST_DISP:    w = '{ACT_NONE,    COND_EDGE_OP, ST_FIND};
         ST_TICK:    w = '{ACT_TICK,    COND_NEVER,   ST_WAIT};
         ST_SCAN:    w = '{ACT_SCAN,    COND_MORE_B,  ST_SCAN};
         ST_FLUSH:   w = '{ACT_FLUSH,   COND_ALWAYS,  ST_WAIT};
         ST_FIND:    w = '{ACT_FIND,    COND_NO_FLAG, ST_WAIT};
         ST_CHECK:   w = '{ACT_NONE,    COND_PRESSED, ST_RELEASE};
         ST_PRESS:   w = '{ACT_PRESS,   COND_ALWAYS,  ST_WAIT};
         ST_RELEASE: w = '{ACT_RELEASE, COND_ALWAYS,  ST_WAIT};
         default:    w = '{ACT_NONE,    COND_ALWAYS,  ST_WAIT};
      endcase
      return w;
   endfunction

endpackage

// File: src/multi_button_short_long_press.sv
// Top level of the short and long button press classifier.
//
// Request channel (req_): one word per item. req_op = 0 is a time tick that
// advances the tick counter and scans held buttons for long presses;
// req_op = 1 is an edge word, of which only the lowest flagged button counts.
// Result channel (rsp_): one word per event, rsp_last marks the final event of
// the request. An edge gives at most one short-press event; a tick gives up to
// eight long-press events in button order.
// Control is a microprogram in a small control store stepped by a program
// counter; one shared subtract-and-compare unit serves all buttons.
// The tick scan visits one button per cycle while no stalled event holds it.
// A new request is taken once the previous one is finished, even while its
// last event waits in the output register. A stalled receiver holds the
// event steady and freezes the program only when a further event must be
// issued.
// Reset (synchronous, active high) clears the press flags, tick counter and
// output valid, and loads debounce 10 and long press 1000 ticks.
// csr_ writes take effect at once and are meant for idle periods.
module multi_button_short_long_press (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [mbslp_pkg::FLAGS_W-1:0] req_edge_flags,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_event_kind,
   output logic [mbslp_pkg::BUTTON_W-1:0] rsp_button,
   output logic                         rsp_last,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [mbslp_pkg::REG_W-1:0]  csr_wdata
);
   import mbslp_pkg::*;

   logic [STEP_W-1:0]          step_ff, step_in;
   logic [REG_W-1:0]           debounce_ff, long_ff;
   logic [ACTIVE_BUTTONS-1:0]  pressed_ff, pressed_in;
   logic [ACTIVE_BUTTONS-1:0]  fired_ff, fired_in;
   logic [COUNT_WIDTH-1:0]     tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0]     start_ff [ACTIVE_BUTTONS];
   logic                       op_ff;
   logic [ACTIVE_BUTTONS-1:0]  flags_ff;
   logic [BIDX_W-1:0]          b_ff, b_in;
   logic                       hold_v_ff, hold_v_in;
   logic [BIDX_W-1:0]          hold_b_ff, hold_b_in;
   logic                       out_v_ff, out_v_in;
   logic                       out_kind_ff, out_kind_in;
   logic [BUTTON_W-1:0]        out_btn_ff, out_btn_in;
   logic                       out_last_ff, out_last_in;

   ctrl_word_type              cw;
   logic                       take;
   logic                       slot_free;
   logic                       emit;
   logic                       stall;
   logic                       jump;
   logic [COUNT_WIDTH-1:0]     held;
   logic [REG_W-1:0]           thr;
   logic                       held_ge;
   logic                       hit;
   logic [BIDX_W-1:0]          low_idx;
   logic                       any_flag;
   logic                       start_we;
   logic [COUNT_WIDTH-1:0]     start_wdata;

   assign cw        = ucode_rom(step_ff);
   assign req_ready = (cw.act == ACT_ACCEPT);
   assign take      = req_valid & req_ready;
   assign slot_free = ~out_v_ff | rsp_ready;

   assign held    = tick_ff - start_ff[b_ff];
   assign thr     = (cw.act == ACT_SCAN) ? long_ff : debounce_ff;
   assign held_ge = (held >= thr);
   assign hit     = pressed_ff[b_ff] & ~fired_ff[b_ff] & held_ge;

   always_comb begin
      low_idx = '0;
      for (int i = ACTIVE_BUTTONS - 1; i >= 0; i--) begin
         if (flags_ff[i]) begin
            low_idx = BIDX_W'(i);
         end
      end
   end
   assign any_flag = |flags_ff;

   always_comb begin
      case (cw.act)
         ACT_SCAN:    emit = hit & hold_v_ff;
         ACT_FLUSH:   emit = hold_v_ff;
         ACT_RELEASE: emit = held_ge & ~fired_ff[b_ff];
         default:     emit = 1'b0;
      endcase
   end
   assign stall = emit & ~slot_free;

   always_comb begin
      case (cw.cond)
         COND_NEVER:   jump = 1'b0;
         COND_ALWAYS:  jump = 1'b1;
         COND_NO_REQ:  jump = ~req_valid;
         COND_EDGE_OP: jump = (op_ff == OP_EDGE);
         COND_MORE_B:  jump = (b_ff != LAST_B);
         COND_NO_FLAG: jump = ~any_flag;
         COND_PRESSED: jump = pressed_ff[b_ff];
         default:      jump = 1'b0;
      endcase
   end

   always_comb begin
      step_in     = step_ff;
      pressed_in  = pressed_ff;
      fired_in    = fired_ff;
      tick_in     = tick_ff;
      b_in        = b_ff;
      hold_v_in   = hold_v_ff;
      hold_b_in   = hold_b_ff;
      out_v_in    = out_v_ff & ~rsp_ready;
      out_kind_in = out_kind_ff;
      out_btn_in  = out_btn_ff;
      out_last_in = out_last_ff;
      start_we    = 1'b0;
      start_wdata = tick_ff;
      if (!stall) begin
         step_in = jump ? cw.target : step_ff + STEP_W'(1);
         if (emit) begin
            out_v_in = 1'b1;
         end
         case (cw.act)
            ACT_TICK: begin
               tick_in = tick_ff + COUNT_WIDTH'(1);
               b_in    = '0;
            end
            ACT_SCAN: begin
               b_in = b_ff + BIDX_W'(1);
               if (hit) begin
                  fired_in[b_ff] = 1'b1;
                  hold_v_in      = 1'b1;
                  hold_b_in      = b_ff;
               end
               if (emit) begin
                  out_kind_in = EVT_LONG;
                  out_btn_in  = BUTTON_W'(hold_b_ff);
                  out_last_in = 1'b0;
               end
            end
            ACT_FLUSH: begin
               hold_v_in = 1'b0;
               if (emit) begin
                  out_kind_in = EVT_LONG;
                  out_btn_in  = BUTTON_W'(hold_b_ff);
                  out_last_in = 1'b1;
               end
            end
            ACT_FIND: begin
               b_in = low_idx;
            end
            ACT_PRESS: begin
               start_we           = 1'b1;
               pressed_in[b_ff]   = 1'b1;
               if (pressed_ff == '0) begin
                  tick_in     = '0;
                  start_wdata = '0;
               end
            end
            ACT_RELEASE: begin
               pressed_in[b_ff] = 1'b0;
               if (held_ge && fired_ff[b_ff]) begin
                  fired_in[b_ff] = 1'b0;
               end
               if (emit) begin
                  out_kind_in = EVT_SHORT;
                  out_btn_in  = BUTTON_W'(b_ff);
                  out_last_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= ST_WAIT;
         debounce_ff <= DEBOUNCE_RESET;
         long_ff     <= LONG_RESET;
         pressed_ff  <= '0;
         fired_ff    <= '0;
         tick_ff     <= '0;
         hold_v_ff   <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         step_ff    <= step_in;
         pressed_ff <= pressed_in;
         fired_ff   <= fired_in;
         tick_ff    <= tick_in;
         hold_v_ff  <= hold_v_in;
         out_v_ff   <= out_v_in;
         if (csr_we) begin
            case (csr_index)
               CSR_DEBOUNCE: debounce_ff <= csr_wdata;
               CSR_LONG:     long_ff     <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff    <= req_op;
         flags_ff <= req_edge_flags[ACTIVE_BUTTONS-1:0];
      end
      b_ff        <= b_in;
      hold_b_ff   <= hold_b_in;
      out_kind_ff <= out_kind_in;
      out_btn_ff  <= out_btn_in;
      out_last_ff <= out_last_in;
   end

   // press start times
   always_ff @(posedge clock) begin
      if (start_we) begin
         start_ff[b_ff] <= start_wdata;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_button     = out_btn_ff;
   assign rsp_last       = out_last_ff;

endmodule

// File: src/mbslp_checker.sv
// Port-level checker for the button press classifier, bound to the top level.
`include "multi_button_short_long_press_macros.svh"

module mbslp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_event_kind,
   input logic [mbslp_pkg::BUTTON_W-1:0] rsp_button,
   input logic                           rsp_last
);
   import mbslp_pkg::*;

   // a stalled word stays put
   `MBSLP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_kind) && $stable(rsp_button) && $stable(rsp_last), "stalled response word changed")

   // an edge never yields more than one event, so a short press closes its word
   `MBSLP_ASSERT_IMP(a_short_last, rsp_valid && rsp_event_kind == EVT_SHORT, rsp_last, "short press not marked last")

   // one word at a time: no acceptance in the cycle after one
   `MBSLP_ASSERT_NXT(a_req_gap, req_valid && req_ready, !req_ready, "request taken on consecutive cycles")

   // nothing is offered straight after reset
   `MBSLP_ASSERT_IMP(a_reset_quiet, $past(reset), !rsp_valid, "response valid after reset")

endmodule

bind multi_button_short_long_press mbslp_checker u_mbslp_checker (.*);
